[src/relative_maximum_finder_core_assert.svh]
// Assertion macros shared by the peak finder modules.
// Each macro expands to a concurrent assertion in simulation and to nothing in synthesis.
`ifndef RELATIVE_MAXIMUM_FINDER_CORE_ASSERT_SVH
`define RELATIVE_MAXIMUM_FINDER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge while out of reset.
`define RMF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// Check that a condition always implies another in the same cycle.
`define RMF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");

`else

`define RMF_ASSERT(lbl, clk, rst_n, prop)
`define RMF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`endif

`endif

[src/rmf_pkg.sv]
package rmf_pkg;

  localparam int MAX_COLS        = 512;
  localparam int MAX_ROWS        = 4096;
  localparam int SAMPLE_BITS     = 16;
  localparam int PEAK_LIMIT_MAX  = 1024;

  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COLS_W   = COL_W + 1;
  localparam int ROWS_W   = ROW_W + 1;
  localparam int CNT_W    = $clog2(PEAK_LIMIT_MAX) + 1;

  // Configuration register widths
  localparam int ROW_CNT_W = 13;
  localparam int COL_CNT_W = 10;
  localparam int LIM_W     = 11;

  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_SCAN_AXIS    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_PEAK_LIMIT   = 2'd3;

  localparam logic KIND_PEAK = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam int MEM_DEPTH = 2 * MAX_COLS;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // Effective (clamped) configuration
  typedef struct packed {
    logic              scan_axis;
    logic [ROWS_W-1:0] rows;
    logic [COLS_W-1:0] cols;
    logic [CNT_W-1:0]  lim;
  } cfg_t;

  // One classified word between front and back
  typedef struct packed {
    logic                          check;
    logic signed [SAMPLE_BITS-1:0] center;
    logic signed [SAMPLE_BITS-1:0] side_a;
    logic signed [SAMPLE_BITS-1:0] side_b;
    logic [ROW_W-1:0]              row;
    logic [COL_W-1:0]              col;
    logic                          last;
  } entry_t;

endpackage

[src/rmf_ram.sv]
module rmf_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Read-first: a read at the write address returns the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

[src/rmf_front.sv]
module rmf_front import rmf_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfg_t                          cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic [QCNT_W-1:0]             q_count_i,
  output logic                          push_o,
  output entry_t                        push_entry_o
);

  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic signed [SAMPLE_BITS-1:0] prev_q, pprev_q;

  logic                          f1_valid_q;
  logic                          f1_vert_q, f1_check_q, f1_last_q;
  logic signed [SAMPLE_BITS-1:0] f1_prev_q, f1_pprev_q, f1_samp_q;
  logic [ROW_W-1:0]              f1_row_q;
  logic [COL_W-1:0]              f1_col_q;

  logic                   accept;
  logic [COLS_W-1:0]      col_nxt;
  logic [ROWS_W-1:0]      row_nxt;
  logic                   col_wrap, row_wrap;
  logic                   hor_en, ver_en;
  logic [MEM_AW-1:0]      addr_cur, addr_oth;
  logic [SAMPLE_BITS-1:0] rd_cur, rd_oth;

  // Stall while the queue plus the word in flight could not take one more.
  assign in_stall_o = ((QCNT_W+1)'(q_count_i) + (QCNT_W+1)'(f1_valid_q))
                      >= (QCNT_W+1)'(QUEUE_DEPTH);
  assign accept = in_valid_i && !in_stall_o;

  assign col_nxt  = COLS_W'(col_q) + COLS_W'(1);
  assign row_nxt  = ROWS_W'(row_q) + ROWS_W'(1);
  assign col_wrap = col_nxt >= cfg_i.cols;
  assign row_wrap = row_nxt >= cfg_i.rows;

  assign hor_en = !cfg_i.scan_axis && (col_q >= COL_W'(2));
  assign ver_en = cfg_i.scan_axis && (row_q >= ROW_W'(2));

  assign addr_cur = {row_q[0], col_q};
  assign addr_oth = {~row_q[0], col_q};

  rmf_ram #(
    .DEPTH (MEM_DEPTH),
    .WIDTH (SAMPLE_BITS)
  ) u_line (
    .clk_i     (clk_i),
    .we_i      (accept),
    .waddr_i   (addr_cur),
    .wdata_i   (sample_i),
    .re_i      (accept),
    .raddr_a_i (addr_cur),
    .raddr_b_i (addr_oth),
    .rdata_a_o (rd_cur),
    .rdata_b_o (rd_oth)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      prev_q     <= '0;
      pprev_q    <= '0;
      f1_valid_q <= 1'b0;
    end else begin
      f1_valid_q <= accept;
      if (accept) begin
        pprev_q <= prev_q;
        prev_q  <= sample_i;
        if (col_wrap) begin
          col_q <= '0;
          row_q <= row_wrap ? '0 : row_nxt[ROW_W-1:0];
        end else begin
          col_q <= col_nxt[COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f1_vert_q  <= ver_en;
      f1_check_q <= hor_en || ver_en;
      f1_last_q  <= col_wrap && row_wrap;
      f1_prev_q  <= prev_q;
      f1_pprev_q <= pprev_q;
      f1_samp_q  <= sample_i;
      f1_row_q   <= ver_en ? row_q - ROW_W'(1) : row_q;
      f1_col_q   <= ver_en ? col_q : col_q - COL_W'(1);
    end
  end

  // Vertical compares take the two rows above from the line store.
  always_comb begin
    push_o              = f1_valid_q;
    push_entry_o.check  = f1_check_q;
    push_entry_o.center = f1_vert_q ? $signed(rd_oth) : f1_prev_q;
    push_entry_o.side_a = f1_vert_q ? $signed(rd_cur) : f1_pprev_q;
    push_entry_o.side_b = f1_samp_q;
    push_entry_o.row    = f1_row_q;
    push_entry_o.col    = f1_col_q;
    push_entry_o.last   = f1_last_q;
  end

endmodule

[src/rmf_queue.sv]
`include "relative_maximum_finder_core_assert.svh"

module rmf_queue import rmf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  entry_t            push_entry_i,
  input  logic              pop_i,
  output entry_t            head_o,
  output logic              head_valid_o,
  output logic [QCNT_W-1:0] count_o
);

  entry_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;

  assign head_o       = slot_q[rd_ptr_q];
  assign head_valid_o = count_q != '0;
  assign count_o      = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      count_q <= count_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

  `RMF_ASSERT_IMPLY(a_no_overflow, clk_i, rst_ni, push_i, count_q != QCNT_W'(QUEUE_DEPTH))
  `RMF_ASSERT_IMPLY(a_no_underflow, clk_i, rst_ni, pop_i, count_q != '0)

endmodule

[src/rmf_back.sv]
`include "relative_maximum_finder_core_assert.svh"

module rmf_back import rmf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  entry_t           head_i,
  input  logic             head_valid_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             record_kind_o,
  output logic [ROW_W-1:0] peak_row_o,
  output logic [COL_W-1:0] peak_col_o,
  output logic [CNT_W-1:0] peaks_found_o,
  output logic             last_o
);

  localparam logic PH_PEAK = 1'b0;
  localparam logic PH_END  = 1'b1;

  function automatic logic is_peak(logic signed [SAMPLE_BITS-1:0] c,
                                   logic signed [SAMPLE_BITS-1:0] a,
                                   logic signed [SAMPLE_BITS-1:0] b);
    return (c >= a && c > b) || (c > a && c >= b);
  endfunction

  logic             phase_q, phase_d;
  logic [CNT_W-1:0] found_q, found_d;
  logic             limit_q, limit_d;
  logic             out_valid_q;
  logic             kind_q, kind_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             last_q, last_d;

  logic             out_free, load, hit;
  logic [CNT_W-1:0] found_inc;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign found_inc = found_q + CNT_W'(1);
  assign hit       = head_i.check && !limit_q && is_peak(head_i.center, head_i.side_a,
                                                         head_i.side_b);

  always_comb begin
    phase_d = phase_q;
    found_d = found_q;
    limit_d = limit_q;
    load    = 1'b0;
    pop_o   = 1'b0;
    kind_d  = KIND_END;
    row_d   = '0;
    col_d   = '0;
    cnt_d   = found_q;
    last_d  = 1'b1;
    if (head_valid_i) begin
      unique case (phase_q)
        PH_END: begin
          if (out_free) begin
            load    = 1'b1;
            pop_o   = 1'b1;
            phase_d = PH_PEAK;
            found_d = '0;
            limit_d = 1'b0;
          end
        end
        PH_PEAK: begin
          if (hit) begin
            if (out_free) begin
              load    = 1'b1;
              kind_d  = KIND_PEAK;
              row_d   = head_i.row;
              col_d   = head_i.col;
              cnt_d   = found_inc;
              last_d  = 1'b0;
              found_d = found_inc;
              limit_d = found_inc >= cfg_i.lim;
              // The end record goes out on the next free cycle.
              if (head_i.last) begin
                phase_d = PH_END;
              end else begin
                pop_o = 1'b1;
              end
            end
          end else if (head_i.last) begin
            if (out_free) begin
              load    = 1'b1;
              pop_o   = 1'b1;
              found_d = '0;
              limit_d = 1'b0;
            end
          end else begin
            pop_o = 1'b1;
          end
        end
        default: phase_d = PH_PEAK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_PEAK;
      found_q     <= '0;
      limit_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      found_q <= found_d;
      limit_q <= limit_d;
      if (out_free) begin
        out_valid_q <= load;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= kind_d;
      row_q  <= row_d;
      col_q  <= col_d;
      cnt_q  <= cnt_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign record_kind_o = kind_q;
  assign peak_row_o    = row_q;
  assign peak_col_o    = col_q;
  assign peaks_found_o = cnt_q;
  assign last_o        = last_q;

  `RMF_ASSERT_IMPLY(a_end_phase_has_word, clk_i, rst_ni, phase_q == PH_END, head_valid_i && head_i.last)
  `RMF_ASSERT_IMPLY(a_last_is_end, clk_i, rst_ni, out_valid_q, last_q == (kind_q == KIND_END))

endmodule

[src/relative_maximum_finder_core.sv]
// Streaming peak finder over a matrix. Samples come in row-major order as signed 16-bit words,
// one per accepted input word; scan_axis picks left/right neighbors (0) or above/below
// neighbors (1). A sample that is >= both neighbors and > at least one is a peak, reported
// as record_kind 0 with its row, column and running count, as soon as its later neighbor has
// arrived. Edge samples along the scanned axis are never peaks. After peak_limit peaks the
// rest of the matrix is ignored. The last sample of every matrix yields an end record
// (record_kind 1, last 1, peaks_found = matrix total, row and column zero). Sustained rate
// is one sample per clock: the front takes a word each cycle that in_stall_o admits, reads
// the two rows above from a two-bank line store (two read ports, one write port, all used
// at acceptance) and pushes the classified word into a four-deep queue; the back emits one
// record per cycle that out_stall_i allows, so a matrix whose last sample also completes a
// peak costs one extra back record, absorbed by the queue. Words pass the front register,
// the queue and the back output register. The line store needs no clearing pass after
// reset. Program registers over APB only while the block is idle; row_count, column_count
// and peak_limit are clamped to their legal ranges (zero acts as one, zero limit as 1024).
module relative_maximum_finder_core import rmf_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [APB_AW-1:0]             paddr,
  input  logic [APB_DW-1:0]             pwdata,
  output logic [APB_DW-1:0]             prdata,
  output logic                          pready,
  // sample input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  // record output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          record_kind_o,
  output logic [ROW_W-1:0]              peak_row_o,
  output logic [COL_W-1:0]              peak_col_o,
  output logic [CNT_W-1:0]              peaks_found_o,
  output logic                          last_o
);

  logic                 scan_axis_q;
  logic [ROW_CNT_W-1:0] row_cnt_q;
  logic [COL_CNT_W-1:0] col_cnt_q;
  logic [LIM_W-1:0]     lim_q;

  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;
  cfg_t                 cfg;

  logic              push, pop, head_valid;
  entry_t            push_entry, head;
  logic [QCNT_W-1:0] q_count;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_axis_q <= 1'b0;
      row_cnt_q   <= ROW_CNT_W'(1);
      col_cnt_q   <= COL_CNT_W'(1);
      lim_q       <= LIM_W'(PEAK_LIMIT_MAX);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SCAN_AXIS:    scan_axis_q <= pwdata[0];
        REG_ROW_COUNT:    row_cnt_q   <= pwdata[ROW_CNT_W-1:0];
        REG_COLUMN_COUNT: col_cnt_q   <= pwdata[COL_CNT_W-1:0];
        REG_PEAK_LIMIT:   lim_q       <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SCAN_AXIS:    prdata = APB_DW'(scan_axis_q);
      REG_ROW_COUNT:    prdata = APB_DW'(row_cnt_q);
      REG_COLUMN_COUNT: prdata = APB_DW'(col_cnt_q);
      REG_PEAK_LIMIT:   prdata = APB_DW'(lim_q);
      default:          prdata = '0;
    endcase
  end

  // Clamp the programmed counts to what the datapath supports.
  always_comb begin
    cfg.scan_axis = scan_axis_q;
    if (row_cnt_q == '0) begin
      cfg.rows = ROWS_W'(1);
    end else if (32'(row_cnt_q) > MAX_ROWS) begin
      cfg.rows = ROWS_W'(MAX_ROWS);
    end else begin
      cfg.rows = ROWS_W'(row_cnt_q);
    end
    if (col_cnt_q == '0) begin
      cfg.cols = COLS_W'(1);
    end else if (32'(col_cnt_q) > MAX_COLS) begin
      cfg.cols = COLS_W'(MAX_COLS);
    end else begin
      cfg.cols = COLS_W'(col_cnt_q);
    end
    if (lim_q == '0 || 32'(lim_q) > PEAK_LIMIT_MAX) begin
      cfg.lim = CNT_W'(PEAK_LIMIT_MAX);
    end else begin
      cfg.lim = CNT_W'(lim_q);
    end
  end

  rmf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .q_count_i    (q_count),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  rmf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid),
    .count_o      (q_count)
  );

  rmf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .head_i        (head),
    .head_valid_i  (head_valid),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .record_kind_o (record_kind_o),
    .peak_row_o    (peak_row_o),
    .peak_col_o    (peak_col_o),
    .peaks_found_o (peaks_found_o),
    .last_o        (last_o)
  );

endmodule

[tb/relative_maximum_finder_core_checker.sv]
`timescale 1ns / 100ps

module relative_maximum_finder_core_checker import rmf_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [APB_AW-1:0]             paddr,
  input  logic [APB_DW-1:0]             pwdata,
  input  logic                          pready,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic                          record_kind_i,
  input  logic [ROW_W-1:0]              peak_row_i,
  input  logic [COL_W-1:0]              peak_col_i,
  input  logic [CNT_W-1:0]              peaks_found_i,
  input  logic                          last_i,
  output int                            mismatch_count_o,
  output int                            records_pending_o
);

  typedef struct packed {
    logic             kind;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [CNT_W-1:0] count;
    logic             last;
  } peak_record_t;

  // register copies, raw as written
  logic                 scan_axis_q;
  logic [ROW_CNT_W-1:0] row_count_q;
  logic [COL_CNT_W-1:0] column_count_q;
  logic [LIM_W-1:0]     peak_limit_q;

  logic signed [SAMPLE_BITS-1:0] line_mem [MEM_DEPTH];
  logic signed [SAMPLE_BITS-1:0] newest_sample;
  logic signed [SAMPLE_BITS-1:0] older_sample;
  int                            row_pos;
  int                            col_pos;
  int                            peak_total;
  bit                            search_done;
  int                            mismatches;
  peak_record_t                  expected_records[$];

  function automatic bit exceeds_neighbors(input logic signed [SAMPLE_BITS-1:0] mid,
                                           input logic signed [SAMPLE_BITS-1:0] side_a,
                                           input logic signed [SAMPLE_BITS-1:0] side_b);
    return (mid >= side_a && mid > side_b) || (mid > side_a && mid >= side_b);
  endfunction

  // Advance the matrix walk by one sample and queue the records it yields.
  task automatic scan_sample(input logic signed [SAMPLE_BITS-1:0] s);
    int           rows_eff;
    int           cols_eff;
    int           lim_eff;
    int           r;
    int           c;
    int           cur_base;
    int           other_base;
    int           hit_row;
    int           hit_col;
    bit           hit;
    peak_record_t rec;
    rows_eff = (row_count_q == 0) ? 1 : (row_count_q > MAX_ROWS ? MAX_ROWS : int'(row_count_q));
    cols_eff = (column_count_q == 0) ? 1 :
               (column_count_q > MAX_COLS ? MAX_COLS : int'(column_count_q));
    lim_eff  = (peak_limit_q == 0 || peak_limit_q > PEAK_LIMIT_MAX) ? PEAK_LIMIT_MAX :
               int'(peak_limit_q);
    r = row_pos;
    c = (col_pos < MAX_COLS) ? col_pos : MAX_COLS - 1;
    cur_base   = (r % 2) * MAX_COLS;
    other_base = ((r + 1) % 2) * MAX_COLS;
    hit     = 1'b0;
    hit_row = 0;
    hit_col = 0;
    if (!search_done) begin
      if (!scan_axis_q && c >= 2) begin
        hit     = exceeds_neighbors(newest_sample, older_sample, s);
        hit_row = r;
        hit_col = c - 1;
      end else if (scan_axis_q && r >= 2) begin
        // row r-1 sits in the other bank, row r-2 in the current one
        hit     = exceeds_neighbors(line_mem[other_base + c], line_mem[cur_base + c], s);
        hit_row = r - 1;
        hit_col = c;
      end
      if (hit) begin
        peak_total++;
        rec.kind  = KIND_PEAK;
        rec.row   = hit_row[ROW_W-1:0];
        rec.col   = hit_col[COL_W-1:0];
        rec.count = peak_total[CNT_W-1:0];
        rec.last  = 1'b0;
        expected_records.push_back(rec);
        if (peak_total >= lim_eff) search_done = 1'b1;
      end
    end
    line_mem[cur_base + c] = s;
    older_sample  = newest_sample;
    newest_sample = s;
    if (c + 1 >= cols_eff) begin
      col_pos = 0;
      if (r + 1 >= rows_eff) begin
        rec.kind  = KIND_END;
        rec.row   = '0;
        rec.col   = '0;
        rec.count = peak_total[CNT_W-1:0];
        rec.last  = 1'b1;
        expected_records.push_back(rec);
        row_pos     = 0;
        peak_total  = 0;
        search_done = 1'b0;
      end else begin
        row_pos = r + 1;
      end
    end else begin
      col_pos = c + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_axis_q    = 1'b0;
      row_count_q    = ROW_CNT_W'(1);
      column_count_q = COL_CNT_W'(1);
      peak_limit_q   = LIM_W'(PEAK_LIMIT_MAX);
      for (int i = 0; i < MEM_DEPTH; i++) line_mem[i] = '0;
      newest_sample = '0;
      older_sample  = '0;
      row_pos       = 0;
      col_pos       = 0;
      peak_total    = 0;
      search_done   = 1'b0;
      mismatches    = 0;
      expected_records.delete();
      mismatch_count_o  <= 0;
      records_pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[REG_IDX_W+1:2])
          REG_SCAN_AXIS:    scan_axis_q    = pwdata[0];
          REG_ROW_COUNT:    row_count_q    = pwdata[ROW_CNT_W-1:0];
          REG_COLUMN_COUNT: column_count_q = pwdata[COL_CNT_W-1:0];
          REG_PEAK_LIMIT:   peak_limit_q   = pwdata[LIM_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) scan_sample(sample_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_records.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected record: kind %0d row %0d col %0d count %0d last %0d",
                     record_kind_i, peak_row_i, peak_col_i, peaks_found_i, last_i);
        end else begin
          peak_record_t want;
          want = expected_records.pop_front();
          if (want.kind !== record_kind_i || want.row !== peak_row_i ||
              want.col !== peak_col_i || want.count !== peaks_found_i ||
              want.last !== last_i) begin
            mismatches++;
            if (mismatches <= 10)
              $display("record mismatch: expected kind %0d row %0d col %0d count %0d last %0d, got kind %0d row %0d col %0d count %0d last %0d",
                       want.kind, want.row, want.col, want.count, want.last,
                       record_kind_i, peak_row_i, peak_col_i, peaks_found_i, last_i);
          end
        end
      end
      mismatch_count_o  <= mismatches;
      records_pending_o <= expected_records.size();
    end
  end

endmodule

[tb/relative_maximum_finder_core_tb.sv]
`timescale 1ns / 100ps

module relative_maximum_finder_core_tb;
  import rmf_pkg::*;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [APB_AW-1:0]             paddr;
  logic [APB_DW-1:0]             pwdata;
  logic [APB_DW-1:0]             prdata;
  logic                          pready;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic signed [SAMPLE_BITS-1:0] sample_i;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic                          record_kind_o;
  logic [ROW_W-1:0]              peak_row_o;
  logic [COL_W-1:0]              peak_col_o;
  logic [CNT_W-1:0]              peaks_found_o;
  logic                          last_o;

  int mismatch_count;
  int records_pending;

  // When set, the matching side never idles: gives stretches at full rate.
  bit in_quiet  = 1'b0;
  bit out_quiet = 1'b0;
  int stall_budget;

  always #10 clk_i = ~clk_i;

  relative_maximum_finder_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_i      (sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .record_kind_o (record_kind_o),
    .peak_row_o    (peak_row_o),
    .peak_col_o    (peak_col_o),
    .peaks_found_o (peaks_found_o),
    .last_o        (last_o)
  );

  // The checker snoops the register port and both channels, predicts every
  // record and reports how many went wrong and how many are still owed.
  relative_maximum_finder_core_checker peak_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .sample_i          (sample_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .record_kind_i     (record_kind_o),
    .peak_row_i        (peak_row_o),
    .peak_col_i        (peak_col_o),
    .peaks_found_i     (peaks_found_o),
    .last_i            (last_o),
    .mismatch_count_o  (mismatch_count),
    .records_pending_o (records_pending)
  );

  // Draw how many cycles a side holds off before its next word.
  function automatic int draw_wait(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 6);
  endfunction

  // Mix full-range words, a narrow band around zero that makes ties common,
  // and the two's-complement extremes, along with -1 and 0.
  function automatic logic signed [SAMPLE_BITS-1:0] draw_sample();
    case ($urandom_range(0, 3))
      0:       return SAMPLE_BITS'($urandom);
      1, 2:    return SAMPLE_BITS'($urandom_range(0, 6) - 3);
      default: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh8000;
          1:       return 16'sh7FFF;
          2:       return -16'sd1;
          default: return 16'sd0;
        endcase
      end
    endcase
  endfunction

  // Receiver: after each accepted record, hold stall high for a drawn number
  // of cycles, then drop it again.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_budget = 0;
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) stall_budget = draw_wait(out_quiet);
      else if (stall_budget > 0) stall_budget--;
      out_stall_i <= (stall_budget != 0);
    end
  end

  // Present one sample word after a random gap and hold it until accepted.
  // Valid stays high on return so back-to-back words need no extra edge.
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
    int gap;
    gap = draw_wait(in_quiet);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid, let the checker see the last word, drain every owed record,
  // then give the pipeline a few more cycles for words that yield no record.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (records_pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // One APB write: setup cycle, then access cycle until pready, then a
  // spare cycle so back-to-back writes never retoggle psel in one step.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_matrix(input logic axis, input logic [ROW_CNT_W-1:0] rows,
                                input logic [COL_CNT_W-1:0] cols,
                                input logic [LIM_W-1:0] limit);
    write_reg(REG_SCAN_AXIS, APB_DW'(axis));
    write_reg(REG_ROW_COUNT, APB_DW'(rows));
    write_reg(REG_COLUMN_COUNT, APB_DW'(cols));
    write_reg(REG_PEAK_LIMIT, APB_DW'(limit));
  endtask

  initial begin
    logic signed [SAMPLE_BITS-1:0] ramp [11] = '{1, 2, 3, 4, 9, 8, 7, 6, 1, 1, 1};
    int                            sent;
    int                            n_items;
    logic                          axis;
    logic [ROW_CNT_W-1:0]          rows_w;
    logic [COL_CNT_W-1:0]          cols_w;
    logic [LIM_W-1:0]              limit_w;

    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    in_valid_i <= 1'b0;
    sample_i   <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset config is a 1x1 matrix: every word closes a matrix on its own.
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sd0);
    send_sample(-16'sd1);

    // Three-wide rows: a tie on one side still counts, and the last word
    // both completes a peak and closes the matrix.
    wait_idle();
    write_reg(REG_COLUMN_COUNT, 3);
    send_sample(16'sd0);
    send_sample(16'sd5);
    send_sample(16'sd5);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);

    // Limit of one: the second candidate is dropped, the end record follows.
    wait_idle();
    write_reg(REG_COLUMN_COUNT, 5);
    write_reg(REG_PEAK_LIMIT, 1);
    foreach (ramp[i]) if (i < 5) send_sample(SAMPLE_BITS'(i % 2));

    // Change counts and axis in the middle of a matrix: stop partway into
    // row two of a 4x4 matrix, then shrink to 3x3 and scan columns. The
    // column already sits past the new last one and wraps; all line store
    // reads hit entries written earlier in this matrix.
    wait_idle();
    write_reg(REG_ROW_COUNT, 4);
    write_reg(REG_COLUMN_COUNT, 4);
    write_reg(REG_PEAK_LIMIT, 0);
    foreach (ramp[i]) send_sample(ramp[i]);
    wait_idle();
    write_reg(REG_SCAN_AXIS, 1);
    write_reg(REG_COLUMN_COUNT, 3);
    write_reg(REG_ROW_COUNT, 3);
    send_sample(16'sd5);

    // Tall single column through clamping (zero columns, zero limit), scanned
    // down the column; one peak lands on the next to last row.
    wait_idle();
    program_matrix(1'b1, 13'd200, 10'd0, 11'd0);
    for (int k = 0; k < 200; k++)
      send_sample((k % 4 == 3 || k == 198) ? 16'sd100 : 16'sd0);

    // Widest row through clamping, alternating extremes, limit above max.
    wait_idle();
    program_matrix(1'b0, 13'd1, 10'd1023, 11'd2047);
    for (int k = 0; k < MAX_COLS; k++) send_sample(k[0] ? 16'sh7FFF : 16'sh8000);

    // Random matrices: mostly small, now and then a larger one, each with
    // fresh settings and its own idling pattern. Top the run up to about
    // 1150 words in all.
    sent = 0;
    while (sent < 410) begin
      axis   = 1'($urandom_range(0, 1));
      rows_w = ROW_CNT_W'(($urandom_range(0, 15) == 0) ? $urandom_range(7, 40) :
                                                          $urandom_range(0, 6));
      cols_w = COL_CNT_W'(($urandom_range(0, 19) == 0) ? $urandom_range(11, 80) :
                                                          $urandom_range(0, 10));
      case ($urandom_range(0, 2))
        0:       limit_w = LIM_W'($urandom_range(1, 3));
        1:       limit_w = '0;
        default: limit_w = LIM_W'($urandom_range(1, 2047));
      endcase
      wait_idle();
      program_matrix(axis, rows_w, cols_w, limit_w);
      in_quiet  = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      n_items = ((rows_w == 0) ? 1 : int'(rows_w)) * ((cols_w == 0) ? 1 : int'(cols_w));
      repeat (n_items) send_sample(draw_sample());
      sent += n_items;
    end

    wait_idle();
    if (mismatch_count == 0 && records_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
